// ===== design/kprt_pkg.sv =====
// ----------------------------------------------------------------------------
// Key press/release tracker package
// Shared constants, codes and payload types of the tracker core.
// ----------------------------------------------------------------------------
package kprt_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int MAX_RESULTS   = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CHAR_W    = 8;
    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CHAR_W-1:0] ESC_BYTE    = 8'h1B;
    localparam logic [CHAR_W-1:0] UPPER_A     = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 1'b1;

    localparam logic [CFG_W-1:0] DOWN_TIMEOUT_RST = 32'd500;
    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = 32'd50;

    typedef enum logic {
        OP_CHAR  = 1'b0,
        OP_SWEEP = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_DROP = 2'd2
    } t_event_kind;

    typedef struct packed {
        t_opcode             opcode;
        logic [CHAR_W-1:0]   char_code;
        logic [STAMP_W-1:0]  timestamp;
    } t_cmd;

    typedef struct packed {
        t_event_kind         event_kind;
        logic [CHAR_W-1:0]   key_code;
        logic                shift_flag;
        logic                last_event;
    } t_result;

    typedef struct packed {
        t_opcode             opcode;
        logic [CHAR_W-1:0]   key;
        logic                shift;
        logic [STAMP_W-1:0]  timestamp;
    } t_work;

    typedef struct packed {
        logic [CFG_W-1:0]    down_timeout;
        logic [CFG_W-1:0]    repeat_delay;
    } t_cfg;

endpackage

// ===== design/kprt_front.sv =====
// ----------------------------------------------------------------------------
// Tracker front end
// Classifies accepted items: folds case, handles escape and batch abort,
// and forwards work for the slot table.
// ----------------------------------------------------------------------------
module kprt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  kprt_pkg::t_cmd  i_cmd,
    output logic            o_push,
    output kprt_pkg::t_work o_work
);
    import kprt_pkg::*;

    logic r_aborted;
    logic n_aborted;
    logic is_upper;

    assign is_upper = (i_cmd.char_code >= UPPER_A) && (i_cmd.char_code <= UPPER_Z);

    always_comb begin
        n_aborted        = r_aborted;
        o_push           = 1'b0;
        o_work.opcode    = i_cmd.opcode;
        o_work.key       = is_upper ? (i_cmd.char_code + CASE_OFFSET) : i_cmd.char_code;
        o_work.shift     = is_upper;
        o_work.timestamp = i_cmd.timestamp;
        if (i_accept) begin
            case (i_cmd.opcode)
                OP_CHAR: begin
                    if (!r_aborted) begin
                        if (i_cmd.char_code == ESC_BYTE) begin
                            n_aborted = 1'b1;
                        end else begin
                            o_push = 1'b1;
                        end
                    end
                end
                OP_SWEEP: begin
                    if (r_aborted) begin
                        n_aborted = 1'b0;
                    end else begin
                        o_push = 1'b1;
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aborted <= 1'b0;
        end else begin
            r_aborted <= n_aborted;
        end
    end

endmodule

// ===== design/kprt_queue.sv =====
// ----------------------------------------------------------------------------
// Tracker work queue
// Short FIFO of classified items between the front end and the slot table.
// ----------------------------------------------------------------------------
module kprt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kprt_pkg::t_work i_work,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output kprt_pkg::t_work o_work
);
    import kprt_pkg::*;

    t_work              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_work  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/kprt_back.sv =====
// ----------------------------------------------------------------------------
// Tracker slot table
// Holds tracked keys, matches characters against all slots in parallel,
// and walks the slots one at a time on a release sweep.
// ----------------------------------------------------------------------------
module kprt_back #(
    parameter int SLOTS     = kprt_pkg::SLOTS_DEF,
    parameter int TIME_BITS = kprt_pkg::TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kprt_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  kprt_pkg::t_work   i_q_work,
    output logic              o_q_pop,
    output logic              o_result_strobe,
    output kprt_pkg::t_result o_result
);
    import kprt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int CMP_W  = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE,
        S_SW_RD,
        S_SW_EV,
        S_SW_END
    } t_state;

    t_state                r_state;
    t_work                 r_cur;
    logic [SLOTS-1:0]      r_valid;
    logic [SLOT_W-1:0]     r_idx;
    logic [SLOT_W-1:0]     r_hit_idx;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_pend_v;
    logic [CHAR_W-1:0]     r_pend_key;
    logic                  r_pend_shift;
    logic                  r_out_strobe;
    t_result               r_out;

    logic [CHAR_W-1:0]     r_key   [SLOTS];
    logic                  r_shift [SLOTS];
    logic                  r_rep   [SLOTS];
    logic [TIME_BITS-1:0]  r_time  [SLOTS];
    logic [CHAR_W-1:0]     r_key_q;
    logic                  r_shift_q;
    logic                  r_rep_q;
    logic [TIME_BITS-1:0]  r_time_q;

    logic [TIME_BITS-1:0]  now;
    logic [TIME_BITS-1:0]  elapsed;
    logic [CMP_W-1:0]      elapsed_x;
    logic [CMP_W-1:0]      limit_x;
    logic                  hit;
    logic [SLOT_W-1:0]     hit_idx;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  we_new;
    logic                  we_upd;
    logic                  set_rep;
    logic [SLOT_W-1:0]     wr_addr;
    logic                  expired;
    logic                  sweep_done;

    assign now       = TIME_BITS'(r_cur.timestamp);
    assign elapsed   = now - r_time_q;
    assign elapsed_x = CMP_W'(elapsed);
    assign limit_x   = r_rep_q ? CMP_W'(i_cfg.repeat_delay) : CMP_W'(i_cfg.down_timeout);

    always_comb begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i]) begin
                if ((r_key[i] == r_cur.key) && (r_shift[i] == r_cur.shift)) begin
                    hit     = 1'b1;
                    hit_idx = SLOT_W'(i);
                end
            end else begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign rd_addr    = (r_state == S_MATCH) ? hit_idx : r_idx;
    assign we_new     = (r_state == S_MATCH) && !hit && free_found;
    assign we_upd     = (r_state == S_UPDATE);
    assign set_rep    = !r_rep_q && (elapsed_x <= CMP_W'(i_cfg.down_timeout));
    assign wr_addr    = we_new ? free_idx : r_hit_idx;
    assign expired    = r_valid[r_idx] && (elapsed_x > limit_x);
    assign sweep_done = (r_idx == SLOT_W'(SLOTS - 1))
                     || (expired && ((r_cnt + CNT_W'(1)) == CNT_W'(MAX_RESULTS)));
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (we_new) begin
            r_key[wr_addr]   <= r_cur.key;
            r_shift[wr_addr] <= r_cur.shift;
            r_rep[wr_addr]   <= 1'b0;
        end
        if (we_upd && set_rep) begin
            r_rep[wr_addr] <= 1'b1;
        end
        if (we_new || we_upd) begin
            r_time[wr_addr] <= now;
        end
        r_key_q   <= r_key[rd_addr];
        r_shift_q <= r_shift[rd_addr];
        r_rep_q   <= r_rep[rd_addr];
        r_time_q  <= r_time[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_idx        <= '0;
            r_hit_idx    <= '0;
            r_cnt        <= '0;
            r_pend_v     <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cur    <= i_q_work;
                        r_idx    <= '0;
                        r_cnt    <= '0;
                        r_pend_v <= 1'b0;
                        r_state  <= (i_q_work.opcode == OP_SWEEP) ? S_SW_RD : S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_hit_idx <= hit_idx;
                    if (hit) begin
                        r_state <= S_UPDATE;
                    end else begin
                        if (free_found) begin
                            r_valid[free_idx] <= 1'b1;
                        end
                        r_out_strobe       <= 1'b1;
                        r_out.event_kind   <= free_found ? EV_DOWN : EV_DROP;
                        r_out.key_code     <= r_cur.key;
                        r_out.shift_flag   <= r_cur.shift;
                        r_out.last_event   <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                S_UPDATE: begin
                    r_state <= S_IDLE;
                end
                S_SW_RD: begin
                    r_state <= S_SW_EV;
                end
                S_SW_EV: begin
                    if (expired) begin
                        if (r_pend_v) begin
                            r_out_strobe     <= 1'b1;
                            r_out.event_kind <= EV_UP;
                            r_out.key_code   <= r_pend_key;
                            r_out.shift_flag <= r_pend_shift;
                            r_out.last_event <= 1'b0;
                        end
                        r_pend_v       <= 1'b1;
                        r_pend_key     <= r_key_q;
                        r_pend_shift   <= r_shift_q;
                        r_valid[r_idx] <= 1'b0;
                        r_cnt          <= r_cnt + CNT_W'(1);
                    end
                    if (sweep_done) begin
                        r_state <= S_SW_END;
                    end else begin
                        r_idx   <= r_idx + SLOT_W'(1);
                        r_state <= S_SW_RD;
                    end
                end
                S_SW_END: begin
                    if (r_pend_v) begin
                        r_out_strobe     <= 1'b1;
                        r_out.event_kind <= EV_UP;
                        r_out.key_code   <= r_pend_key;
                        r_out.shift_flag <= r_pend_shift;
                        r_out.last_event <= 1'b1;
                    end
                    r_pend_v <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_strobe = r_out_strobe;
    assign o_result        = r_out;

endmodule

// ===== design/key_press_release_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Key press/release tracker core
// Infers key-down, key-up and key-dropped events from timestamped terminal
// bytes and end-of-batch sweep commands.
//
// Command channel: an item is taken at a rising edge with i_start high and
// o_busy low. o_busy is high while the two-entry work queue is full.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data writes a
// register; o_cfg_ready is always high. Write only while the core is idle.
// Results: each event is on o_result for one cycle with o_result_strobe
// high; last_event marks the final event of an item. The receiver cannot
// stall the core.
// Timing: a character goes from the idle state to a match state, and to an
// update state when its key is tracked (no event then); a new or dropped
// key's event is registered in the match state. A sweep walks the slots
// one at a time, a read and an event state per slot (registered read of
// the slot time store), then an end state; each key-up event is held
// until the next expired slot is found or the walk ends. Escape bytes and
// aborted batches are consumed by the front end with no result.
// Reset: clears the slot valid bits, the abort flag, the queue and sets the
// configuration registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_press_release_tracker_core #(
    parameter int SLOTS     = kprt_pkg::SLOTS_DEF,
    parameter int TIME_BITS = kprt_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  kprt_pkg::t_cmd                  i_cmd,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kprt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kprt_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                            o_result_strobe,
    output kprt_pkg::t_result               o_result
);
    import kprt_pkg::*;

    t_cfg   r_cfg;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    logic   push;
    t_work  push_work;
    t_work  head_work;

    assign o_busy      = q_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.down_timeout <= DOWN_TIMEOUT_RST;
            r_cfg.repeat_delay <= REPEAT_DELAY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DOWN_TIMEOUT: r_cfg.down_timeout <= i_cfg_data;
                CFG_REPEAT_DELAY: r_cfg.repeat_delay <= i_cfg_data;
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    kprt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_start && !q_full),
        .i_cmd    (i_cmd),
        .o_push   (push),
        .o_work   (push_work)
    );

    kprt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_work   (push_work),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_full   (q_full),
        .o_work   (head_work)
    );

    kprt_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_q_work        (head_work),
        .o_q_pop         (q_pop),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule
